FILE: hw/rtl/ahc_pkg.sv
// Shared types and constants of the ARGB to HSV converter.
`timescale 1ns / 1ps

package ahc_pkg;

   localparam int CH_W    = 8;   // one colour channel
   localparam int QUO_W   = 17;  // widest quotient (saturation before clamping)
   localparam int STEP_W  = 5;   // divider step counter
   localparam int HUE_W   = 15;
   localparam int SAT_W   = 16;

   localparam logic [STEP_W-1:0] SAT_STEPS = 5'd17;
   localparam logic [STEP_W-1:0] HUE_STEPS = 5'd12;

   localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;  // 360 degrees
   localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;   // 120 degrees
   localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;  // 240 degrees

   // Request to the shared divider: the dividend arrives pre-split into the
   // starting partial remainder and the bits still to be shifted in.
   typedef struct packed {
      logic              start;
      logic [CH_W-1:0]   divisor;
      logic [CH_W-1:0]   rem_init;
      logic [QUO_W-1:0]  quo_init;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/ahc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, shared by saturation and hue.
`timescale 1ns / 1ps

module ahc_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ahc_pkg::div_req_type div_req,
   output ahc_pkg::div_rsp_type div_rsp
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [ahc_pkg::STEP_W-1:0]     cnt_ff, cnt_in;
   logic [ahc_pkg::CH_W-1:0]       divisor_ff, divisor_in;
   logic [ahc_pkg::CH_W-1:0]       rem_ff, rem_in;
   logic [ahc_pkg::QUO_W-1:0]      quo_ff, quo_in;

   logic [ahc_pkg::CH_W:0]         trial;
   logic [ahc_pkg::CH_W:0]         diff;
   logic                           fits;

   // partial remainder always stays below the divisor, so nine bits carry the trial
   assign trial = {rem_ff, quo_ff[ahc_pkg::QUO_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = div_req.steps;
         divisor_in = div_req.divisor;
         rem_in     = div_req.rem_init;
         quo_in     = div_req.quo_init;
      end else if (busy_ff) begin
         rem_in = fits ? diff[ahc_pkg::CH_W-1:0] : trial[ahc_pkg::CH_W-1:0];
         quo_in = {quo_ff[ahc_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/argb_to_hsv_converter.sv
// Top level of the ARGB to HSV converter: sequencer, sector logic and result register.
`timescale 1ns / 1ps

// ARGB to HSV converter.
//
// Input channel req_*: one packed ARGB pixel per word (alpha 31-24, red 23-16,
// green 15-8, blue 7-0). Result channel rsp_*: hue in 1/64 degree, saturation
// in Q16, value (largest channel), alpha passed through and a grey flag.
// A word moves on a rising edge with valid high and stall low.
//
// One pixel is worked at a time. After the input word is taken, state S_PREP
// finds max, min and the hue sector, then the shared serial divider forms the
// saturation quotient (17 steps) and, for a coloured pixel, the hue quotient
// (12 steps), one quotient bit per cycle. The result is then registered, and
// the next word is taken only once the result of the last one is registered.
//
// req_stall is high whenever a pixel is in work. A finished result waits in
// the output register while rsp_stall is high; the next pixel may already be
// taken and worked, and is held back at the end until the register frees.
// Reset (synchronous) empties the block and clears the held hue to red.

module argb_to_hsv_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_argb,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_hue,
   output logic [15:0] rsp_saturation,
   output logic [7:0]  rsp_value_level,
   output logic [7:0]  rsp_alpha_out,
   output logic        rsp_grey
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_SAT_GO,
      S_SAT_WAIT,
      S_HUE_GO,
      S_HUE_WAIT,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

   localparam int CW = ahc_pkg::CH_W;
   localparam int HW = ahc_pkg::HUE_W;

   state_type             state_ff, state_in;
   sector_type            sector_ff, sector_in;

   // pixel being worked
   logic [CW-1:0]         alpha_ff, alpha_in;
   logic [CW-1:0]         red_ff, red_in;
   logic [CW-1:0]         green_ff, green_in;
   logic [CW-1:0]         blue_ff, blue_in;
   logic [CW-1:0]         max_ff, max_in;
   logic [CW-1:0]         delta_ff, delta_in;
   logic [CW-1:0]         mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [ahc_pkg::SAT_W-1:0] sat_ff, sat_in;
   logic [HW-1:0]         hue_ff, hue_in;
   logic                  grey_ff, grey_in;
   logic [HW-1:0]         held_hue_ff, held_hue_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0]         rsp_hue_ff, rsp_hue_in;
   logic [ahc_pkg::SAT_W-1:0] rsp_sat_ff, rsp_sat_in;
   logic [CW-1:0]         rsp_value_ff, rsp_value_in;
   logic [CW-1:0]         rsp_alpha_ff, rsp_alpha_in;
   logic                  rsp_grey_ff, rsp_grey_in;

   ahc_pkg::div_req_type  div_req;
   ahc_pkg::div_rsp_type  div_rsp;

   // combinational helpers
   logic [CW-1:0]         c_max, c_min;
   logic [CW:0]           c_num;
   logic [CW+3:0]         mag_x15;      // mag * 15; times 256 gives mag * 3840
   logic [11:0]           quo12;
   logic [HW-1:0]         quo15;

   ahc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // max, min and numerator of the hue fraction from the captured channels
   always_comb begin
      if (red_ff > green_ff) begin
         c_max = (red_ff > blue_ff) ? red_ff : blue_ff;
      end else begin
         c_max = (green_ff > blue_ff) ? green_ff : blue_ff;
      end
      if (red_ff < green_ff) begin
         c_min = (red_ff < blue_ff) ? red_ff : blue_ff;
      end else begin
         c_min = (green_ff < blue_ff) ? green_ff : blue_ff;
      end
      // red wins ties, then green
      if (c_max == red_ff) begin
         sector_in = SEC_RED;
         c_num     = {1'b0, green_ff} - {1'b0, blue_ff};
      end else if (c_max == green_ff) begin
         sector_in = SEC_GREEN;
         c_num     = {1'b0, blue_ff} - {1'b0, red_ff};
      end else begin
         sector_in = SEC_BLUE;
         c_num     = {1'b0, red_ff} - {1'b0, green_ff};
      end
   end

   assign mag_x15 = {mag_ff, 4'b0000} - {4'b0000, mag_ff};
   assign quo12   = div_rsp.quotient[11:0];
   assign quo15   = {3'b000, quo12};

   // feed the shared divider: saturation is (delta << 16) / max,
   // hue is (mag * 3840) / delta
   always_comb begin
      div_req.start = (state_ff == S_SAT_GO) || (state_ff == S_HUE_GO);
      if (state_ff == S_HUE_GO) begin
         div_req.divisor  = delta_ff;
         div_req.rem_init = mag_x15[CW+3:4];
         div_req.quo_init = {mag_x15[3:0], 13'd0};
         div_req.steps    = ahc_pkg::HUE_STEPS;
      end else begin
         div_req.divisor  = max_ff;
         div_req.rem_init = {1'b0, delta_ff[CW-1:1]};
         div_req.quo_init = {delta_ff[0], 16'd0};
         div_req.steps    = ahc_pkg::SAT_STEPS;
      end
   end

   always_comb begin
      state_in     = state_ff;
      alpha_in     = alpha_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      max_in       = max_ff;
      delta_in     = delta_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      hue_in       = hue_ff;
      grey_in      = grey_ff;
      held_hue_in  = held_hue_ff;
      rsp_hue_in   = rsp_hue_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_value_in = rsp_value_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_grey_in  = rsp_grey_ff;

      // drop the result once the receiver takes it
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               alpha_in = req_pixel_argb[31:24];
               red_in   = req_pixel_argb[23:16];
               green_in = req_pixel_argb[15:8];
               blue_in  = req_pixel_argb[7:0];
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            max_in   = c_max;
            delta_in = c_max - c_min;
            grey_in  = (c_max == c_min);
            neg_in   = c_num[CW];
            mag_in   = c_num[CW] ? (~c_num[CW-1:0] + 1'b1) : c_num[CW-1:0];
            state_in = S_SAT_GO;
         end
         S_SAT_GO: begin
            state_in = S_SAT_WAIT;
         end
         S_SAT_WAIT: begin
            if (div_rsp.done) begin
               // black gives zero; delta equal to max clamps to all ones
               if (max_ff == '0) begin
                  sat_in = '0;
               end else if (div_rsp.quotient[ahc_pkg::QUO_W-1]) begin
                  sat_in = '1;
               end else begin
                  sat_in = div_rsp.quotient[ahc_pkg::SAT_W-1:0];
               end
               state_in = grey_ff ? S_FINISH : S_HUE_GO;
            end
         end
         S_HUE_GO: begin
            state_in = S_HUE_WAIT;
         end
         S_HUE_WAIT: begin
            if (div_rsp.done) begin
               case (sector_ff)
                  SEC_RED: begin
                     // a negative red hue wraps round by a full turn
                     hue_in = (neg_ff && (quo12 != '0)) ? (ahc_pkg::HUE_FULL - quo15) : quo15;
                  end
                  SEC_GREEN: begin
                     hue_in = neg_ff ? (ahc_pkg::HUE_GREEN - quo15)
                                     : (ahc_pkg::HUE_GREEN + quo15);
                  end
                  SEC_BLUE: begin
                     hue_in = neg_ff ? (ahc_pkg::HUE_BLUE - quo15)
                                     : (ahc_pkg::HUE_BLUE + quo15);
                  end
                  default: begin
                     hue_in = quo15;
                  end
               endcase
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = sat_ff;
               rsp_value_in = max_ff;
               rsp_alpha_in = alpha_ff;
               rsp_grey_in  = grey_ff;
               if (grey_ff) begin
                  rsp_hue_in = held_hue_ff;
               end else begin
                  rsp_hue_in  = hue_ff;
                  held_hue_in = hue_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         held_hue_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_hue_ff  <= held_hue_in;
      end
      sector_ff    <= (state_ff == S_PREP) ? sector_in : sector_ff;
      alpha_ff     <= alpha_in;
      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
      max_ff       <= max_in;
      delta_ff     <= delta_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      sat_ff       <= sat_in;
      hue_ff       <= hue_in;
      grey_ff      <= grey_in;
      rsp_hue_ff   <= rsp_hue_in;
      rsp_sat_ff   <= rsp_sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_grey_ff  <= rsp_grey_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hue         = rsp_hue_ff;
   assign rsp_saturation  = rsp_sat_ff;
   assign rsp_value_level = rsp_value_ff;
   assign rsp_alpha_out   = rsp_alpha_ff;
   assign rsp_grey        = rsp_grey_ff;

   // the divider only reports back while a pixel is being worked
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_rsp.done)
      else $error("divider finished with no pixel in work");

   // a taken word closes the input straight away
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input reopened straight after a word was taken");

   // a grey result never carries saturation
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_grey) |-> (rsp_saturation == '0))
      else $error("grey result with non-zero saturation");

   // hue always lies below a full turn
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue < ahc_pkg::HUE_FULL))
      else $error("hue out of range");

endmodule
